// ===== rtl/b5cs_pkg.sv =====
// ----------------------------------------------------------------------------
// Big5 content scorer package
// Shared widths, constants and types for the scorer and its byte classifier.
// ----------------------------------------------------------------------------
package b5cs_pkg;

   localparam int SCORE_WIDTH = 16;
   localparam int MATCH_WIDTH = 17;
   localparam int OUT_WIDTH   = 16;
   localparam int CAP_WIDTH   = (SCORE_WIDTH > OUT_WIDTH) ? SCORE_WIDTH : OUT_WIDTH;

   localparam logic [OUT_WIDTH-1:0] OUT_MAX = '1;

   localparam logic [7:0] BYTE_NUL      = 8'h00;
   localparam logic [7:0] BYTE_TAB      = 8'h09;
   localparam logic [7:0] BYTE_LF       = 8'h0A;
   localparam logic [7:0] BYTE_CR       = 8'h0D;
   localparam logic [7:0] CONTROL_LIMIT = 8'd32;
   localparam logic [7:0] HIGH_BIT      = 8'h80;
   localparam logic [7:0] LEAD_LO       = 8'h81;
   localparam logic [7:0] LEAD_HI       = 8'hFE;
   localparam logic [7:0] TRAIL_LO_A    = 8'h40;
   localparam logic [7:0] TRAIL_HI_A    = 8'h7E;
   localparam logic [7:0] TRAIL_LO_B    = 8'hA1;
   localparam logic [7:0] TRAIL_HI_B    = 8'hFE;

   typedef enum logic [1:0] {
      KIND_REJECT,
      KIND_CONTROL,
      KIND_ASCII,
      KIND_LEAD
   } byte_kind_type;

   typedef struct packed {
      byte_kind_type kind;
      logic          trail_ok;
   } byte_class_type;

endpackage

// ===== rtl/b5cs_stream_if.sv =====
// ----------------------------------------------------------------------------
// Big5 content scorer channels
// Valid/ready channels for text bytes in and match scores out.
// ----------------------------------------------------------------------------
interface b5cs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       is_last;

   modport source (output valid, output text_byte, output is_last, input ready);
   modport sink   (input valid, input text_byte, input is_last, output ready);
endinterface

interface b5cs_rsp_if import b5cs_pkg::*;;
   logic                          valid;
   logic                          ready;
   logic signed [MATCH_WIDTH-1:0] match_score;

   modport source (output valid, output match_score, input ready);
   modport sink   (input valid, input match_score, output ready);
endinterface

// ===== rtl/b5cs_byte_class.sv =====
// ----------------------------------------------------------------------------
// Big5 byte classifier
// Sorts one byte into reject, control, ASCII or lead, and flags a valid trail.
// ----------------------------------------------------------------------------
module b5cs_byte_class import b5cs_pkg::*; (
   input  logic [7:0]     text_byte,
   output byte_class_type byte_class
);

   always_comb begin
      byte_class.trail_ok = (text_byte inside {[TRAIL_LO_A:TRAIL_HI_A],
                                               [TRAIL_LO_B:TRAIL_HI_B]});
      if (text_byte == BYTE_NUL) begin
         byte_class.kind = KIND_REJECT;
      end else if (text_byte < CONTROL_LIMIT) begin
         // Tab, LF and CR count as ordinary text.
         if (text_byte inside {BYTE_TAB, BYTE_LF, BYTE_CR}) begin
            byte_class.kind = KIND_ASCII;
         end else begin
            byte_class.kind = KIND_CONTROL;
         end
      end else if (text_byte < HIGH_BIT) begin
         byte_class.kind = KIND_ASCII;
      end else if (text_byte inside {[LEAD_LO:LEAD_HI]}) begin
         byte_class.kind = KIND_LEAD;
      end else begin
         byte_class.kind = KIND_REJECT;
      end
   end

endmodule

// ===== rtl/big5_content_scorer_unit.sv =====
// ----------------------------------------------------------------------------
// Big5 content scorer
// Scores a byte buffer for Big5 fitness and reports one score per buffer.
// ----------------------------------------------------------------------------
// The unit takes one text byte per clock on req_chan and, on the word flagged
// is_last, returns one match score on rsp_chan: the saturated score, or -1 if
// the buffer was rejected. A byte is held in an input register, where a
// combinational classify-and-update step advances the running score; the
// result of a last byte goes to an output register that drives rsp_chan.
// Throughput is one byte per clock; the only stall is a last byte waiting
// while the previous score is unread. Scoring state returns to zero after
// every last byte.
module big5_content_scorer_unit import b5cs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   b5cs_req_if.sink  req_chan,
   b5cs_rsp_if.source rsp_chan
);

   logic                          stage_valid_ff, stage_valid_in;
   logic [7:0]                    stage_byte_ff;
   logic                          stage_last_ff;
   logic [SCORE_WIDTH-1:0]        score_ff, score_in;
   logic                          await_ff, await_in;
   logic                          rejected_ff, rejected_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [MATCH_WIDTH-1:0] rsp_score_ff, rsp_score_in;

   byte_class_type                byte_class;
   logic                          out_free;
   logic                          advance;
   logic [1:0]                    step_add;
   logic                          step_dec;
   logic [SCORE_WIDTH:0]          score_sum;
   logic [SCORE_WIDTH-1:0]        score_upd;
   logic                          await_upd;
   logic                          rejected_upd;
   logic [CAP_WIDTH-1:0]          score_wide;
   logic [OUT_WIDTH-1:0]          score_capped;

   b5cs_byte_class u_byte_class (
      .text_byte  (stage_byte_ff),
      .byte_class (byte_class)
   );

   assign out_free         = !rsp_valid_ff || rsp_chan.ready;
   assign advance          = stage_valid_ff && (!stage_last_ff || out_free);
   assign req_chan.ready   = !stage_valid_ff || advance;
   assign stage_valid_in   = req_chan.valid || (stage_valid_ff && !advance);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.match_score = rsp_score_ff;

   always_comb begin
      step_add     = 2'd0;
      step_dec     = 1'b0;
      await_upd    = await_ff;
      rejected_upd = rejected_ff;
      // Once rejected, bytes are ignored until the end of the buffer.
      if (!rejected_ff) begin
         if (await_ff) begin
            await_upd = 1'b0;
            if (byte_class.trail_ok) begin
               step_add = 2'd2;
            end else begin
               rejected_upd = 1'b1;
            end
         end else begin
            case (byte_class.kind)
               KIND_CONTROL: step_dec = 1'b1;
               KIND_ASCII:   step_add = 2'd1;
               KIND_LEAD: begin
                  if (stage_last_ff) begin
                     step_add = 2'd1;
                  end else begin
                     await_upd = 1'b1;
                  end
               end
               default:      rejected_upd = 1'b1;
            endcase
         end
      end
   end

   always_comb begin
      score_sum = {1'b0, score_ff} + (SCORE_WIDTH + 1)'(step_add);
      if (step_dec) begin
         score_upd = (score_ff != '0) ? score_ff - SCORE_WIDTH'(1) : score_ff;
      end else if (score_sum[SCORE_WIDTH]) begin
         score_upd = '1;
      end else begin
         score_upd = score_sum[SCORE_WIDTH-1:0];
      end
   end

   always_comb begin
      score_wide = CAP_WIDTH'(score_upd);
      if (score_wide > CAP_WIDTH'(OUT_MAX)) begin
         score_capped = OUT_MAX;
      end else begin
         score_capped = score_wide[OUT_WIDTH-1:0];
      end
   end

   always_comb begin
      score_in     = score_ff;
      await_in     = await_ff;
      rejected_in  = rejected_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_score_in = rsp_score_ff;
      if (advance) begin
         if (stage_last_ff) begin
            score_in     = '0;
            await_in     = 1'b0;
            rejected_in  = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_score_in = rejected_upd ? '1 :
                           $signed({{(MATCH_WIDTH - OUT_WIDTH){1'b0}}, score_capped});
         end else begin
            score_in    = score_upd;
            await_in    = await_upd;
            rejected_in = rejected_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         score_ff       <= '0;
         await_ff       <= 1'b0;
         rejected_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         score_ff       <= score_in;
         await_ff       <= await_in;
         rejected_ff    <= rejected_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         stage_byte_ff <= req_chan.text_byte;
         stage_last_ff <= req_chan.is_last;
      end
      rsp_score_ff <= rsp_score_in;
   end

endmodule

// ===== verif/big5_content_scorer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Big5 content scorer testbench
// Streams text buffers into the scorer and checks every match score against
// a local scoring model. A directed set of short buffers covers each byte
// class and each rejection cause. Random buffers follow, most of them clean
// Big5 and ASCII text, the rest noise, broken sequences and buffers that end
// on a lead byte. One long buffer at the end builds up a large score.
// The sender works in random bursts and the receiver stalls on a pattern of
// its own, with one long hold-off that backs the scorer up to its input.
// ----------------------------------------------------------------------------
module big5_content_scorer_unit_tb;
   import b5cs_pkg::*;

   localparam longint SCORE_LIMIT      = (longint'(1) << SCORE_WIDTH) - 1;
   localparam int     RANDOM_WORDS     = 1600;
   localparam int     LONG_PAIRS       = 100;
   localparam int     HOLD_TRIGGER     = 200;
   localparam int     HOLD_CYCLES      = 300;
   localparam int     DRAIN_CYCLES     = 20;
   localparam int     TIMEOUT_CYCLES   = 3_000_000;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       is_last;
   } text_word_t;

   typedef enum {STYLE_CLEAN, STYLE_NOISE, STYLE_BROKEN, STYLE_LEAD_END} buffer_style_e;
   typedef enum {READY_ALWAYS, READY_PATTERN, READY_RANDOM} ready_style_e;

   logic clock = 1'b0;
   logic reset;

   b5cs_req_if req_chan ();
   b5cs_rsp_if rsp_chan ();

   big5_content_scorer_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   text_word_t                    pending_words[$];
   logic [7:0]                    buffer_bytes[$];
   logic signed [MATCH_WIDTH-1:0] expected_scores[$];

   // Scoring state of the local model.
   logic [SCORE_WIDTH-1:0] scored_total = '0;
   logic                   trail_pending = 1'b0;
   logic                   buffer_rejected = 1'b0;

   int   words_accepted = 0;
   int   error_count = 0;
   int   gap_left;
   int   burst_left;
   int   hold_left;
   logic hold_done;

   ready_style_e ready_style;
   logic [6:0]   ready_phase;
   logic [15:0]  stall_pattern;

   task automatic add_to_score(input int unsigned amount);
      longint sum;
      sum = longint'(scored_total) + amount;
      scored_total = (sum > SCORE_LIMIT) ? SCORE_LIMIT[SCORE_WIDTH-1:0] : sum[SCORE_WIDTH-1:0];
   endtask

   task automatic score_text_word(input logic [7:0] text_byte, input logic is_last);
      longint capped;
      if (!buffer_rejected) begin
         if (trail_pending) begin
            trail_pending = 1'b0;
            if ((text_byte >= TRAIL_LO_A && text_byte <= TRAIL_HI_A) ||
                (text_byte >= TRAIL_LO_B && text_byte <= TRAIL_HI_B))
               add_to_score(2);
            else
               buffer_rejected = 1'b1;
         end else if (text_byte == BYTE_NUL) begin
            buffer_rejected = 1'b1;
         end else if (text_byte < CONTROL_LIMIT && text_byte != BYTE_TAB &&
                      text_byte != BYTE_LF && text_byte != BYTE_CR) begin
            if (scored_total != 0)
               scored_total = scored_total - 1'b1;
         end else if (text_byte < HIGH_BIT) begin
            add_to_score(1);
         end else if (text_byte >= LEAD_LO && text_byte <= LEAD_HI) begin
            if (is_last)
               add_to_score(1);
            else
               trail_pending = 1'b1;
         end else begin
            buffer_rejected = 1'b1;
         end
      end
      if (is_last) begin
         capped = (longint'(scored_total) > longint'(OUT_MAX)) ? longint'(OUT_MAX)
                                                               : longint'(scored_total);
         if (buffer_rejected)
            expected_scores.push_back('1);
         else
            expected_scores.push_back(capped[MATCH_WIDTH-1:0]);
         scored_total    = '0;
         trail_pending   = 1'b0;
         buffer_rejected = 1'b0;
      end
   endtask

   task automatic push_word(input logic [7:0] text_byte, input logic is_last);
      text_word_t w;
      w.text_byte = text_byte;
      w.is_last   = is_last;
      pending_words.push_back(w);
   endtask

   task automatic flush_buffer();
      for (int i = 0; i < buffer_bytes.size(); i++)
         push_word(buffer_bytes[i], i == buffer_bytes.size() - 1);
      buffer_bytes.delete();
   endtask

   function automatic logic [7:0] random_lead();
      return 8'($urandom_range(LEAD_LO, LEAD_HI));
   endfunction

   function automatic logic [7:0] random_trail();
      if ($urandom_range(0, 1) == 0)
         return 8'($urandom_range(TRAIL_LO_A, TRAIL_HI_A));
      return 8'($urandom_range(TRAIL_LO_B, TRAIL_HI_B));
   endfunction

   // Bytes from 0x20 to 0x7F most of the time, otherwise white space or a control byte.
   function automatic logic [7:0] random_single();
      int         pick;
      logic [7:0] b;
      pick = $urandom_range(0, 9);
      if (pick < 7)
         return 8'($urandom_range(8'h20, 8'h7F));
      if (pick == 7) begin
         case ($urandom_range(0, 2))
            0: return BYTE_TAB;
            1: return BYTE_LF;
            default: return BYTE_CR;
         endcase
      end
      b = 8'($urandom_range(1, CONTROL_LIMIT - 1));
      while (b == BYTE_TAB || b == BYTE_LF || b == BYTE_CR)
         b = 8'($urandom_range(1, CONTROL_LIMIT - 1));
      return b;
   endfunction

   task automatic append_clean(input int count);
      int left;
      left = count;
      while (left > 0) begin
         if (left >= 2 && $urandom_range(0, 2) == 0) begin
            buffer_bytes.push_back(random_lead());
            buffer_bytes.push_back(random_trail());
            left -= 2;
         end else begin
            buffer_bytes.push_back(random_single());
            left -= 1;
         end
      end
   endtask

   always @(posedge clock) begin : sender
      text_word_t w;
      if (reset) begin
         req_chan.valid     <= 1'b0;
         req_chan.text_byte <= '0;
         req_chan.is_last   <= 1'b0;
         gap_left           <= 0;
         burst_left         <= 0;
         words_accepted     <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            score_text_word(req_chan.text_byte, req_chan.is_last);
            words_accepted <= words_accepted + 1;
         end
         if (req_chan.valid && !req_chan.ready) begin
            // The word stays on the bus until the scorer takes it.
         end else if (gap_left != 0) begin
            req_chan.valid <= 1'b0;
            gap_left       <= gap_left - 1;
         end else if (pending_words.size() != 0) begin
            w = pending_words.pop_front();
            req_chan.valid     <= 1'b1;
            req_chan.text_byte <= w.text_byte;
            req_chan.is_last   <= w.is_last;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // One long receiver hold-off, early in the random part, so that scores
   // back up and the scorer stops taking bytes.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && words_accepted >= HOLD_TRIGGER) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin : receiver
      logic signed [MATCH_WIDTH-1:0] want;
      logic                          go;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         ready_phase    <= '0;
         ready_style    <= READY_ALWAYS;
         stall_pattern  <= 16'hA5C3;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_scores.size() == 0) begin
               $error("match_score: no score expected, got %0d", rsp_chan.match_score);
               error_count++;
            end else begin
               want = expected_scores.pop_front();
               if (rsp_chan.match_score !== want) begin
                  $error("match_score: expected %0d, got %0d", want, rsp_chan.match_score);
                  error_count++;
               end
            end
         end
         ready_phase <= ready_phase + 1'b1;
         if (ready_phase == 0) begin
            ready_style   <= ready_style_e'($urandom_range(0, 2));
            stall_pattern <= 16'($urandom) | 16'h0001;
         end else begin
            stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
         end
         case (ready_style)
            READY_ALWAYS:  go = 1'b1;
            READY_PATTERN: go = stall_pattern[0];
            default:       go = ($urandom_range(0, 1) == 1);
         endcase
         rsp_chan.ready <= go && (hold_left == 0);
      end
   end

   initial begin : stimulus
      int            random_words;
      int            len;
      int            cut;
      buffer_style_e style;

      reset = 1'b1;

      // Control, white space and ASCII bytes, then valid pairs from both trail ranges.
      push_word(8'h01, 1'b0);
      push_word(8'h41, 1'b0);
      push_word(BYTE_TAB, 1'b0);
      push_word(BYTE_LF, 1'b0);
      push_word(BYTE_CR, 1'b0);
      push_word(8'h1F, 1'b0);
      push_word(8'h7F, 1'b0);
      push_word(LEAD_LO, 1'b0);
      push_word(TRAIL_LO_A, 1'b0);
      push_word(LEAD_HI, 1'b0);
      push_word(TRAIL_HI_A, 1'b0);
      push_word(8'hA4, 1'b0);
      push_word(TRAIL_LO_B, 1'b0);
      push_word(8'hA4, 1'b0);
      push_word(TRAIL_HI_B, 1'b1);
      // A control byte at zero score leaves the score at zero.
      push_word(8'h01, 1'b0);
      push_word(8'h20, 1'b1);
      // A lead byte as the only and final byte.
      push_word(LEAD_HI, 1'b1);
      // Rejections: NUL with a swallowed byte after it, 0x80, 0xFF.
      push_word(BYTE_NUL, 1'b0);
      push_word(8'hFF, 1'b1);
      push_word(HIGH_BIT, 1'b1);
      push_word(8'hFF, 1'b1);
      // A bad trail byte in the last position, and NUL as a trail byte.
      push_word(LEAD_LO, 1'b0);
      push_word(8'h3F, 1'b1);
      push_word(8'hB0, 1'b0);
      push_word(BYTE_NUL, 1'b1);

      random_words = 0;
      while (random_words < RANDOM_WORDS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: style = STYLE_CLEAN;
            6:                style = STYLE_NOISE;
            7, 8:             style = STYLE_BROKEN;
            default:          style = STYLE_LEAD_END;
         endcase
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
         case (style)
            STYLE_CLEAN: append_clean(len);
            STYLE_NOISE: repeat (len) buffer_bytes.push_back(8'($urandom));
            STYLE_BROKEN: begin
               cut = $urandom_range(0, len - 1);
               append_clean(cut);
               case ($urandom_range(0, 5))
                  0: buffer_bytes.push_back(BYTE_NUL);
                  1: buffer_bytes.push_back(HIGH_BIT);
                  2: buffer_bytes.push_back(8'hFF);
                  3: begin
                     buffer_bytes.push_back(random_lead());
                     buffer_bytes.push_back(8'($urandom_range(0, TRAIL_LO_A - 1)));
                  end
                  4: begin
                     buffer_bytes.push_back(random_lead());
                     buffer_bytes.push_back(8'($urandom_range(TRAIL_HI_A + 1, TRAIL_LO_B - 1)));
                  end
                  default: begin
                     buffer_bytes.push_back(random_lead());
                     buffer_bytes.push_back(8'hFF);
                  end
               endcase
               // Whatever follows the break is swallowed.
               repeat (len - 1 - cut) buffer_bytes.push_back(8'($urandom));
            end
            default: begin
               append_clean(len - 1);
               buffer_bytes.push_back(random_lead());
            end
         endcase
         random_words += buffer_bytes.size();
         flush_buffer();
      end

      // One long buffer of pairs builds up a large score, then a control
      // byte steps it down and ASCII takes it back up.
      repeat (LONG_PAIRS) begin
         push_word(random_lead(), 1'b0);
         push_word(random_trail(), 1'b0);
      end
      push_word(8'h02, 1'b0);
      push_word(8'h61, 1'b0);
      push_word(8'h62, 1'b0);
      push_word(8'h63, 1'b1);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_chan.valid || expected_scores.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin : watchdog
      repeat (TIMEOUT_CYCLES) @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/b5cs_pkg.sv
rtl/b5cs_stream_if.sv
rtl/b5cs_byte_class.sv
rtl/big5_content_scorer_unit.sv
verif/big5_content_scorer_unit_tb.sv
